// ===== rtl/assert_macros.svh =====
// Assertion macros for the cooling scheduler RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ECS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ECS_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ECS_ASSERT(lbl, clk, rstn, prop)
`define ECS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== rtl/ecs_pkg.sv =====
// Shared widths, register indexes, reset values and control structs
// for the exponential cooling scheduler. No dependencies.
package ecs_pkg;

    localparam int TICK_W  = 48;
    localparam int ITER_W  = 32;
    localparam int STEP_W  = 16;
    localparam int DECAY_W = 16;
    localparam int TEMP_W  = 32;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;
    localparam int DIVN_W  = TICK_W + STEP_W;
    localparam int DCNT_W  = $clog2(DIVN_W + 1);

    localparam logic [IDX_W-1:0] CFG_MAX_ITER   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_TOTAL_TICK = 3'd1;
    localparam logic [IDX_W-1:0] CFG_NUM_STEPS  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DECAY      = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INIT_TEMP  = 3'd4;

    localparam logic [ITER_W-1:0]  RST_MAX_ITER   = 32'd1000000;
    localparam logic [TICK_W-1:0]  RST_TOTAL_TICK = 48'd1000000000;
    localparam logic [STEP_W-1:0]  RST_NUM_STEPS  = 16'd100;
    localparam logic [DECAY_W-1:0] RST_DECAY      = 16'd64880;
    localparam logic [TEMP_W-1:0]  RST_INIT_TEMP  = 32'd65536;

    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic tgt;
        logic step;
        logic load_out;
    } ecs_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic step_owed;
        logic out_free;
    } ecs_status_t;

endpackage

// ===== rtl/ecs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on ecs_pkg for widths.
module ecs_div
    import ecs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [TICK_W-1:0] divisor,
    output logic [DIVN_W-1:0] quotient,
    output logic              busy
);

    logic [DIVN_W-1:0] quo_reg, quo_next;
    logic [TICK_W-1:0] rem_reg, rem_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [TICK_W:0]   rem_sh;
    logic [TICK_W+1:0] diff;
    logic              ge;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIVN_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, divisor};
        ge       = !diff[TICK_W+1];
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = DCNT_W'(DIVN_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[DIVN_W-2:0], ge};
            rem_next = ge ? diff[TICK_W-1:0] : rem_sh[TICK_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign busy     = (cnt_reg != '0);

endmodule

// ===== rtl/ecs_dpath.sv =====
// Datapath: configuration registers, schedule state, share dividers,
// decay multiplier and output register. Depends on ecs_pkg and ecs_div.
module ecs_dpath
    import ecs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ecs_cmd_t          cmd,
    output ecs_status_t       st,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic [TICK_W-1:0] elapsed_ticks,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [TEMP_W-1:0] temperature,
    output logic [STEP_W-1:0] step_reached
);

    logic [ITER_W-1:0]  max_iter_reg;
    logic [TICK_W-1:0]  total_tick_reg;
    logic [STEP_W-1:0]  num_steps_reg;
    logic [DECAY_W-1:0] decay_reg;

    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic [STEP_W-1:0]  steps_done_reg, steps_done_next;
    logic [TEMP_W-1:0]  temp_now_reg, temp_now_next;
    logic               out_valid_reg, out_valid_next;

    logic [TICK_W-1:0]         elapsed_reg;
    logic [TICK_W+STEP_W-1:0]  prod_time_reg;
    logic [ITER_W+STEP_W-1:0]  prod_iter_reg;
    logic [STEP_W-1:0]         target_reg;
    logic [TEMP_W-1:0]         temp_out_reg;
    logic [STEP_W-1:0]         step_out_reg;

    logic [DIVN_W-1:0]          q_time, q_iter;
    logic                       busy_time, busy_iter;
    logic [STEP_W-1:0]          cap_time, cap_iter, target_next;
    logic [TEMP_W+DECAY_W-1:0]  decay_prod;

    ecs_div u_div_time (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_time_reg),
        .divisor  (total_tick_reg),
        .quotient (q_time),
        .busy     (busy_time)
    );

    ecs_div u_div_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({{(DIVN_W-ITER_W-STEP_W){1'b0}}, prod_iter_reg}),
        .divisor  ({{(TICK_W-ITER_W){1'b0}}, max_iter_reg}),
        .quotient (q_iter),
        .busy     (busy_iter)
    );

    always_comb
    begin
        cap_time = (q_time > {{(DIVN_W-STEP_W){1'b0}}, num_steps_reg}) ?
                   num_steps_reg : q_time[STEP_W-1:0];
        cap_iter = (q_iter > {{(DIVN_W-STEP_W){1'b0}}, num_steps_reg}) ?
                   num_steps_reg : q_iter[STEP_W-1:0];
        target_next = (cap_time > cap_iter) ? cap_time : cap_iter;
        decay_prod  = temp_now_reg * decay_reg;

        iter_next = iter_reg;
        if (cmd.accept && (iter_reg != '1))
            iter_next = iter_reg + 1'b1;

        steps_done_next = steps_done_reg;
        temp_now_next   = temp_now_reg;
        if (cmd.step)
        begin
            steps_done_next = steps_done_reg + 1'b1;
            temp_now_next   = decay_prod[TEMP_W+DECAY_W-1:DECAY_W];
        end
        else if (cfg_we && (cfg_index == CFG_INIT_TEMP) && (steps_done_reg == '0))
            temp_now_next = cfg_data[TEMP_W-1:0];

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= RST_MAX_ITER;
            total_tick_reg <= RST_TOTAL_TICK;
            num_steps_reg  <= RST_NUM_STEPS;
            decay_reg      <= RST_DECAY;
            iter_reg       <= '0;
            steps_done_reg <= '0;
            temp_now_reg   <= RST_INIT_TEMP;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_ITER:   max_iter_reg   <= cfg_data[ITER_W-1:0];
                    CFG_TOTAL_TICK: total_tick_reg <= cfg_data[TICK_W-1:0];
                    CFG_NUM_STEPS:  num_steps_reg  <= cfg_data[STEP_W-1:0];
                    CFG_DECAY:      decay_reg      <= cfg_data[DECAY_W-1:0];
                    default:        ;
                endcase
            end
            iter_reg       <= iter_next;
            steps_done_reg <= steps_done_next;
            temp_now_reg   <= temp_now_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            elapsed_reg <= elapsed_ticks;
        if (cmd.mul)
        begin
            prod_time_reg <= elapsed_reg * num_steps_reg;
            prod_iter_reg <= iter_reg * num_steps_reg;
        end
        if (cmd.tgt)
            target_reg <= target_next;
        if (cmd.load_out)
        begin
            temp_out_reg <= temp_now_reg;
            step_out_reg <= steps_done_reg;
        end
    end

    assign st.div_busy  = busy_time | busy_iter;
    assign st.step_owed = (steps_done_reg < target_reg);
    assign st.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign temperature  = temp_out_reg;
    assign step_reached = step_out_reg;

endmodule

// ===== rtl/ecs_ctrl.sv =====
// Controller state machine sequencing one request through the datapath.
// Depends on ecs_pkg for the command and status structs.
module ecs_ctrl
    import ecs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  ecs_status_t st,
    output ecs_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIVS = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_TGT  = 3'd4;
    localparam logic [2:0] S_STEP = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (!st.div_busy)
                    state_next = S_TGT;
            end
            S_TGT:
            begin
                cmd.tgt    = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (st.step_owed)
                    cmd.step = 1'b1;
                else if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/exponential_cooling_schedule.sv =====
// Top level of the annealing temperature scheduler.
// Depends on ecs_pkg, ecs_ctrl, ecs_dpath, ecs_div and assert_macros.svh.
//
// Usage:
//   Input channel: in_valid / in_stall with elapsed_ticks, one word per
//   solver iteration. Output channel: out_valid / out_stall with
//   temperature (Q16.16) and step_reached, one word per input word.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 max_iterations, 1 total_ticks, 2 num_steps, 3 decay_factor,
//   4 initial_temperature); write only while no request is in flight.
//   Sequence: after input acceptance the request passes the multiply, divider start,
//   divide, target and step states before out_valid; the two 64-bit
//   share divisions run side by side at one bit per cycle and the step
//   state applies one multiply per cooling step owed by that request. The
//   next word is taken only after the previous one is loaded, one request at a time.
//   A finished word sits in the output register; a new request is taken
//   while it waits. If the receiver stalls when the next result is ready,
//   the block holds that result until the output register frees.
//   Reset: configuration returns to defaults, iteration count and steps
//   applied clear, temperature returns to the default start value.
`include "assert_macros.svh"
module exponential_cooling_schedule
    import ecs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TICK_W-1:0] elapsed_ticks,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TEMP_W-1:0] temperature,
    output logic [STEP_W-1:0] step_reached
);

    ecs_cmd_t    cmd;
    ecs_status_t st;

    ecs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    ecs_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .elapsed_ticks (elapsed_ticks),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .temperature   (temperature),
        .step_reached  (step_reached)
    );

    `ECS_ASSERT(a_busy_after_accept, clk, rst_n, (in_valid && !in_stall) |=> in_stall)
    `ECS_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid && out_stall)
    `ECS_ASSERT(a_div_runs, clk, rst_n, cmd.div_start |=> st.div_busy)
    `ECS_NEVER(a_step_vs_out, clk, rst_n, cmd.step && cmd.load_out)

endmodule

// ===== tb/sv/cooling_checker.sv =====
`timescale 1ns / 1ps
// Checker for the exponential cooling scheduler. It watches the register port and both word
// channels, predicts every output word and compares it. Depends on ecs_pkg only.
module cooling_checker
    import ecs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [TICK_W-1:0] elapsed_ticks,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [TEMP_W-1:0] temperature,
    input  logic [STEP_W-1:0] step_reached,
    output int                errors,
    output int                in_flight
);

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [STEP_W-1:0] steps;
    } cool_word_t;

    logic [ITER_W-1:0]  iter_budget;
    logic [TICK_W-1:0]  tick_budget;
    logic [STEP_W-1:0]  num_steps;
    logic [DECAY_W-1:0] decay;
    logic [TEMP_W-1:0]  start_temp;

    logic [ITER_W-1:0]  iter_cnt;
    logic [STEP_W-1:0]  steps_done;
    logic [TEMP_W-1:0]  temp_now;

    cool_word_t temp_due_q[$];
    int fail_count = 0;
    int pending = 0;

    assign errors = fail_count;
    assign in_flight = pending;

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        if (fail_count < 50)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    function automatic logic [63:0] step_share(input logic [63:0] amount,
                                               input logic [63:0] budget,
                                               input logic [STEP_W-1:0] steps);
        logic [63:0] prod;
        if (budget == 0)
            return 64'(steps);
        prod = amount * steps;
        return prod / budget;
    endfunction

    // count the request, catch up on owed cooling steps, return the word due
    function automatic cool_word_t advance_cooling(input logic [TICK_W-1:0] ticks);
        logic [63:0] by_time;
        logic [63:0] by_iter;
        logic [63:0] goal;
        logic [47:0] prod;
        cool_word_t w;
        if (iter_cnt != '1)
            iter_cnt++;
        by_time = step_share(64'(ticks), 64'(tick_budget), num_steps);
        by_iter = step_share(64'(iter_cnt), 64'(iter_budget), num_steps);
        goal = (by_time > by_iter) ? by_time : by_iter;
        if (goal > 64'(num_steps))
            goal = 64'(num_steps);
        while (64'(steps_done) < goal)
        begin
            steps_done++;
            prod = temp_now * decay;
            temp_now = prod[47:16];
        end
        w.temp = temp_now;
        w.steps = steps_done;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cool_word_t want;
        if (!rst_n)
        begin
            iter_budget = RST_MAX_ITER;
            tick_budget = RST_TOTAL_TICK;
            num_steps   = RST_NUM_STEPS;
            decay       = RST_DECAY;
            start_temp  = RST_INIT_TEMP;
            iter_cnt    = '0;
            steps_done  = '0;
            temp_now    = RST_INIT_TEMP;
            temp_due_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_ITER:   iter_budget = cfg_data[ITER_W-1:0];
                    CFG_TOTAL_TICK: tick_budget = cfg_data[TICK_W-1:0];
                    CFG_NUM_STEPS:  num_steps = cfg_data[STEP_W-1:0];
                    CFG_DECAY:      decay = cfg_data[DECAY_W-1:0];
                    CFG_INIT_TEMP:
                    begin
                        start_temp = cfg_data[TEMP_W-1:0];
                        if (steps_done == 0)
                            temp_now = start_temp;
                    end
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                temp_due_q.push_back(advance_cooling(elapsed_ticks));
            if (out_valid && !out_stall)
            begin
                if (temp_due_q.size() == 0)
                    report("word with nothing expected", 64'(temperature), 64'd0);
                else
                begin
                    want = temp_due_q.pop_front();
                    if (temperature !== want.temp)
                        report("temperature", 64'(temperature), 64'(want.temp));
                    if (step_reached !== want.steps)
                        report("step_reached", 64'(step_reached), 64'(want.steps));
                end
            end
            pending <= temp_due_q.size();
        end
    end

endmodule

// ===== tb/sv/exponential_cooling_schedule_test.sv =====
`timescale 1ns / 1ps
// Top of the cooling scheduler testbench: clock, reset, register settings, request words and
// output stalls. Depends on ecs_pkg, the scheduler RTL and cooling_checker.
module exponential_cooling_schedule_test;
    import ecs_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [TICK_W-1:0] elapsed_ticks = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [TEMP_W-1:0] temperature;
    logic [STEP_W-1:0] step_reached;

    int errors;
    int in_flight;
    bit idle_on = 1'b0;
    bit hold_go = 1'b0;
    int words_sent = 0;
    int settings_used = 0;

    exponential_cooling_schedule dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .temperature   (temperature),
        .step_reached  (step_reached)
    );

    cooling_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .elapsed_ticks (elapsed_ticks),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .temperature   (temperature),
        .step_reached  (step_reached),
        .errors        (errors),
        .in_flight     (in_flight)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // output side: short stall bursts, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                out_stall <= 1'b1;
                repeat (600) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic [TICK_W-1:0] ticks);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        elapsed_ticks <= ticks;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] iters, input logic [63:0] ticks,
                             input logic [63:0] steps, input logic [63:0] decay,
                             input logic [63:0] start_temp);
        drain();
        put_reg(CFG_MAX_ITER, iters);
        put_reg(CFG_TOTAL_TICK, ticks);
        put_reg(CFG_NUM_STEPS, steps);
        put_reg(CFG_DECAY, decay);
        put_reg(CFG_INIT_TEMP, start_temp);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        logic [63:0] ticks;
        logic [63:0] pace;
        logic [63:0] total;
        logic [63:0] iters;
        logic [63:0] x;
        int ns;
        int decay;
        int pick;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no step due yet
        send_word(48'd0);
        send_word(48'd9_999_999);

        // start temperature loads while no step has been applied
        configure(64'hFFFF_FFFF, 64'd1000, 64'd16, 64'hFFFF, 64'hFFFF_FFFF);
        send_word(48'd0);
        send_word(48'd62);
        send_word(48'd63);
        send_word(48'd125);
        send_word(48'hFFFF_FFFF_FFFF);

        // step count lowered below steps applied; start temperature write has no effect
        configure(64'd1, 64'hFFFF_FFFF_FFFF, 64'd0, 64'h8000, 64'd0);
        send_word(48'h5555_AAAA_5555);
        send_word(48'hAAAA_5555_AAAA);

        // zero iteration budget: every step due
        configure(64'd0, 64'd1, 64'd24, 64'h8000, 64'h1234_5678);
        send_word(48'd0);
        send_word(48'd1);

        // zero time budget: every step due
        configure(64'd1000, 64'd0, 64'd40, 64'hFFF0, 64'hFFFF_FFFF);
        send_word(48'h8000_0000_0000);
        send_word(48'h7FFF_FFFF_FFFF);

        for (int ph = 0; ph < 10; ph++)
        begin
            ns = (ph == 9) ? 65535 : 60 + ph * ph * 300;
            if (ph == 9)
                total = (64'd1 << 40) + 64'($urandom);
            else
                total = 64'($urandom_range(1000, 32'hFFFF_FFFF));
            if (ph == 9 || $urandom_range(0, 1) == 1)
                iters = 64'($urandom_range(32'h8000_0000, 32'hFFFF_FFFF));
            else
                iters = 64'($urandom_range(200, 5000));
            decay = (ph == 7) ? $urandom_range(32768, 65535) : $urandom_range(65300, 65535);
            configure(iters, total, 64'(ns), 64'(decay), 64'($urandom));
            idle_on = (ph != 2) && (ph != 9);
            if (ph == 4)
                hold_go = 1'b1;
            ticks = 0;
            pace = total / 64;
            for (int i = 0; i < 68; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3 && ph != 9)
                    x = {$urandom, $urandom};
                else if (pick < 12)
                    x = ticks * $urandom_range(0, 100) / 100;
                else
                begin
                    ticks += pace * $urandom_range(0, (ph == 9) ? 100 : 200) / 100;
                    x = ticks;
                end
                send_word(x[TICK_W-1:0]);
            end
        end

        // zero decay: the remaining steps drop the temperature to zero
        configure(64'hFFFF_FFFF, total, 64'd65535, 64'd0, 64'hFFFF_FFFF);
        send_word(48'hFFFF_FFFF_FFFF);
        send_word(48'($urandom));
        send_word(48'($urandom));

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d request words over %0d register settings, up to the full step count,",
                 words_sent, settings_used);
        $display("with idle bursts on both channels and one long output hold-off.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ecs_pkg.sv
rtl/ecs_div.sv
rtl/ecs_dpath.sv
rtl/ecs_ctrl.sv
rtl/exponential_cooling_schedule.sv
tb/sv/cooling_checker.sv
tb/sv/exponential_cooling_schedule_test.sv
